// ----- design/k_nearest_window_distance_sum_unit_defines.svh -----
// Assertion macros shared by the nearest-window unit.
`ifndef K_NEAREST_WINDOW_DISTANCE_SUM_UNIT_DEFINES_SVH
`define K_NEAREST_WINDOW_DISTANCE_SUM_UNIT_DEFINES_SVH

// Same-cycle implication on clk with the async reset held off.
`define KNWDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on clk with the async reset held off.
`define KNWDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/knwds_pkg.sv -----
package knwds_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int DEPTH       = MAX_ENTRIES + 1;
    localparam int IDX_W       = $clog2(MAX_ENTRIES + 2);

    localparam int POS_W  = 30;
    localparam int WGT_W  = 32;
    localparam int K_W    = 11;
    localparam int PPRE_W = 41;
    localparam int WPRE_W = 43;
    localparam int ANS_W  = 44;
    localparam int PROD_W = POS_W + IDX_W;
    localparam int CMP_W  = (IDX_W > K_W) ? IDX_W : K_W;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic load;
        logic query;
        logic bad;
        logic s1_rd;
        logic s1_ev;
        logic s2_init;
        logic s2_rd;
        logic s2_ev;
        logic pf1;
        logic pf2;
        logic pf3;
        logic ar1;
        logic ar2;
        logic ar3;
    } cmd_t;

    typedef struct packed {
        logic s1_done;
        logic s2_done;
        logic bad;
    } status_t;

endpackage

// ----- design/knwds_ctrl.sv -----
module knwds_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               operation,
    input  knwds_pkg::status_t status,
    output knwds_pkg::cmd_t    cmd,
    output logic               busy
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_S1_RD = 4'd1;
    localparam logic [3:0] ST_S1_EV = 4'd2;
    localparam logic [3:0] ST_S2_RD = 4'd3;
    localparam logic [3:0] ST_S2_EV = 4'd4;
    localparam logic [3:0] ST_PF2   = 4'd5;
    localparam logic [3:0] ST_PF3   = 4'd6;
    localparam logic [3:0] ST_AR1   = 4'd7;
    localparam logic [3:0] ST_AR2   = 4'd8;
    localparam logic [3:0] ST_AR3   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (operation == knwds_pkg::OP_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (status.bad)
                    begin
                        cmd.bad = 1'b1;
                    end
                    else
                    begin
                        cmd.query  = 1'b1;
                        state_next = ST_S1_RD;
                    end
                end
            end
            ST_S1_RD:
            begin
                if (status.s1_done)
                begin
                    cmd.s2_init = 1'b1;
                    state_next  = ST_S2_RD;
                end
                else
                begin
                    cmd.s1_rd  = 1'b1;
                    state_next = ST_S1_EV;
                end
            end
            ST_S1_EV:
            begin
                cmd.s1_ev  = 1'b1;
                state_next = ST_S1_RD;
            end
            ST_S2_RD:
            begin
                if (status.s2_done)
                begin
                    cmd.pf1    = 1'b1;
                    state_next = ST_PF2;
                end
                else
                begin
                    cmd.s2_rd  = 1'b1;
                    state_next = ST_S2_EV;
                end
            end
            ST_S2_EV:
            begin
                cmd.s2_ev  = 1'b1;
                state_next = ST_S2_RD;
            end
            ST_PF2:
            begin
                cmd.pf2    = 1'b1;
                state_next = ST_PF3;
            end
            ST_PF3:
            begin
                cmd.pf3    = 1'b1;
                state_next = ST_AR1;
            end
            ST_AR1:
            begin
                cmd.ar1    = 1'b1;
                state_next = ST_AR2;
            end
            ST_AR2:
            begin
                cmd.ar2    = 1'b1;
                state_next = ST_AR3;
            end
            ST_AR3:
            begin
                cmd.ar3    = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ----- design/knwds_datapath.sv -----
module knwds_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  knwds_pkg::cmd_t                     cmd,
    output knwds_pkg::status_t                  status,
    input  logic [knwds_pkg::POS_W-1:0]         position_value,
    input  logic signed [knwds_pkg::WGT_W-1:0]  weight_value,
    input  logic [knwds_pkg::POS_W-1:0]         query_point,
    input  logic [knwds_pkg::K_W-1:0]           window_count,
    output logic                                done,
    output logic signed [knwds_pkg::ANS_W-1:0]  answer,
    output logic                                bad_query
);

    localparam int IDX_W  = knwds_pkg::IDX_W;
    localparam int POS_W  = knwds_pkg::POS_W;
    localparam int PPRE_W = knwds_pkg::PPRE_W;
    localparam int WPRE_W = knwds_pkg::WPRE_W;
    localparam int ANS_W  = knwds_pkg::ANS_W;
    localparam int WGT_W  = knwds_pkg::WGT_W;
    localparam int CMP_W  = knwds_pkg::CMP_W;
    localparam int PROD_W = knwds_pkg::PROD_W;

    logic [POS_W-1:0]  pos_mem [0:knwds_pkg::DEPTH-1];
    logic [PPRE_W-1:0] pp_mem  [0:knwds_pkg::DEPTH-1];
    logic [WPRE_W-1:0] wp_mem  [0:knwds_pkg::DEPTH-1];

    logic [IDX_W-1:0]  n_reg, n_next;
    logic [PPRE_W-1:0] pp_last_reg, pp_last_next;
    logic [WPRE_W-1:0] wp_last_reg, wp_last_next;
    logic              done_reg, done_next;

    logic [IDX_W-1:0]  lo_reg, lo_next;
    logic [IDX_W-1:0]  hi_reg, hi_next;
    logic [IDX_W-1:0]  first_reg, first_next;
    logic [IDX_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [POS_W-1:0]  pt_reg, pt_next;
    logic [ANS_W-1:0]  prodl_reg, prodl_next;
    logic [ANS_W-1:0]  prodr_reg, prodr_next;
    logic [PPRE_W-1:0] ppt_reg, ppt_next;
    logic [PPRE_W-1:0] left_reg, left_next;
    logic [PPRE_W-1:0] right_reg, right_next;
    logic [WPRE_W-1:0] wsum_reg, wsum_next;
    logic [ANS_W-1:0]  d1_reg, d1_next;
    logic [ANS_W-1:0]  d2_reg, d2_next;
    logic [ANS_W-1:0]  dist_reg, dist_next;
    logic [ANS_W-1:0]  answer_reg, answer_next;
    logic              bad_reg, bad_next;

    logic [IDX_W-1:0]  pos_addr_a, pos_addr_b;
    logic [IDX_W-1:0]  pp_addr_a, pp_addr_b, wp_addr_a, wp_addr_b;
    logic [POS_W-1:0]  pos_rd_a_reg, pos_rd_b_reg;
    logic [PPRE_W-1:0] pp_rd_a_reg, pp_rd_b_reg;
    logic [WPRE_W-1:0] wp_rd_a_reg, wp_rd_b_reg;
    logic              pp_a_zero_reg, pp_b_zero_reg, wp_a_zero_reg, wp_b_zero_reg;
    logic [PPRE_W-1:0] pp_a_val, pp_b_val;
    logic [WPRE_W-1:0] wp_a_val, wp_b_val;

    logic [IDX_W:0]    mid_sum;
    logic [IDX_W-1:0]  mid;
    logic [IDX_W-1:0]  step;
    logic [IDX_W-1:0]  probe;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  wr_idx;
    logic              wr_en;
    logic [IDX_W-1:0]  k_in;
    logic [WPRE_W-1:0] weight_ext;

    function automatic logic [POS_W-1:0] absdiff(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
        absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid        = mid_sum[IDX_W:1];
    assign step       = count_reg >> 1;
    assign probe      = first_reg + step;
    assign r_idx      = hi_reg + k_reg - IDX_W'(1);
    assign wr_en      = cmd.load && (n_reg < IDX_W'(knwds_pkg::MAX_ENTRIES));
    assign wr_idx     = n_reg + IDX_W'(1);
    assign k_in       = IDX_W'(window_count);
    assign weight_ext = {{(WPRE_W - WGT_W){weight_value[WGT_W-1]}}, weight_value};

    assign status.s1_done = ((lo_reg + IDX_W'(1)) == hi_reg);
    assign status.s2_done = (count_reg == '0);
    assign status.bad     = (window_count == '0)
                         || (CMP_W'(window_count) > CMP_W'(n_reg));

    assign pp_a_val = pp_a_zero_reg ? '0 : pp_rd_a_reg;
    assign pp_b_val = pp_b_zero_reg ? '0 : pp_rd_b_reg;
    assign wp_a_val = wp_a_zero_reg ? '0 : wp_rd_a_reg;
    assign wp_b_val = wp_b_zero_reg ? '0 : wp_rd_b_reg;

    always_comb
    begin
        pos_addr_a = '0;
        pos_addr_b = '0;
        pp_addr_a  = '0;
        pp_addr_b  = '0;
        wp_addr_a  = '0;
        wp_addr_b  = '0;
        if (cmd.s1_rd)
        begin
            pos_addr_a = mid;
            pos_addr_b = mid + k_reg;
        end
        if (cmd.s2_rd)
        begin
            pos_addr_a = probe;
        end
        if (cmd.pf1)
        begin
            pp_addr_a = hi_reg - IDX_W'(1);
            pp_addr_b = first_reg - IDX_W'(1);
            wp_addr_a = hi_reg - IDX_W'(1);
            wp_addr_b = r_idx;
        end
        if (cmd.pf2)
        begin
            pp_addr_a = r_idx;
        end
    end

    always_comb
    begin
        n_next       = n_reg;
        pp_last_next = pp_last_reg;
        wp_last_next = wp_last_reg;
        done_next    = 1'b0;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        first_next   = first_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        pt_next      = pt_reg;
        prodl_next   = prodl_reg;
        prodr_next   = prodr_reg;
        ppt_next     = ppt_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        wsum_next    = wsum_reg;
        d1_next      = d1_reg;
        d2_next      = d2_reg;
        dist_next    = dist_reg;
        answer_next  = answer_reg;
        bad_next     = bad_reg;

        if (wr_en)
        begin
            n_next       = wr_idx;
            pp_last_next = pp_last_reg + PPRE_W'(position_value);
            wp_last_next = wp_last_reg + weight_ext;
        end
        if (cmd.query)
        begin
            pt_next = query_point;
            k_next  = k_in;
            lo_next = '0;
            hi_next = n_reg - k_in + IDX_W'(1);
        end
        if (cmd.bad)
        begin
            answer_next = '0;
            bad_next    = 1'b1;
            done_next   = 1'b1;
        end
        if (cmd.s1_ev)
        begin
            if (absdiff(pos_rd_a_reg, pt_reg) > absdiff(pos_rd_b_reg, pt_reg))
            begin
                lo_next = mid;
            end
            else
            begin
                hi_next = mid;
            end
        end
        if (cmd.s2_init)
        begin
            first_next = hi_reg;
            count_next = k_reg;
        end
        if (cmd.s2_ev)
        begin
            if (!(pt_reg < pos_rd_a_reg))
            begin
                first_next = probe + IDX_W'(1);
                count_next = count_reg - step - IDX_W'(1);
            end
            else
            begin
                count_next = step;
            end
        end
        if (cmd.pf1)
        begin
            prodl_next = ANS_W'(PROD_W'(pt_reg) * PROD_W'(first_reg - hi_reg));
            prodr_next = ANS_W'(PROD_W'(pt_reg) * PROD_W'(hi_reg + k_reg - first_reg));
        end
        if (cmd.pf2)
        begin
            left_next = pp_b_val - pp_a_val;
            ppt_next  = pp_b_val;
            wsum_next = wp_b_val - wp_a_val;
        end
        if (cmd.pf3)
        begin
            right_next = pp_a_val - ppt_reg;
            d1_next    = prodl_reg - ANS_W'(left_reg);
        end
        if (cmd.ar1)
        begin
            d2_next = ANS_W'(right_reg) - prodr_reg;
        end
        if (cmd.ar2)
        begin
            dist_next = d1_reg + d2_reg;
        end
        if (cmd.ar3)
        begin
            answer_next = {{(ANS_W - WPRE_W){wsum_reg[WPRE_W-1]}}, wsum_reg} - dist_reg;
            bad_next    = 1'b0;
            done_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg       <= '0;
            pp_last_reg <= '0;
            wp_last_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            n_reg       <= n_next;
            pp_last_reg <= pp_last_next;
            wp_last_reg <= wp_last_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        first_reg  <= first_next;
        count_reg  <= count_next;
        k_reg      <= k_next;
        pt_reg     <= pt_next;
        prodl_reg  <= prodl_next;
        prodr_reg  <= prodr_next;
        ppt_reg    <= ppt_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        wsum_reg   <= wsum_next;
        d1_reg     <= d1_next;
        d2_reg     <= d2_next;
        dist_reg   <= dist_next;
        answer_reg <= answer_next;
        bad_reg    <= bad_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_mem[wr_idx] <= position_value;
            pp_mem[wr_idx]  <= pp_last_next;
            wp_mem[wr_idx]  <= wp_last_next;
        end
        pos_rd_a_reg  <= pos_mem[pos_addr_a];
        pos_rd_b_reg  <= pos_mem[pos_addr_b];
        pp_rd_a_reg   <= pp_mem[pp_addr_a];
        pp_rd_b_reg   <= pp_mem[pp_addr_b];
        wp_rd_a_reg   <= wp_mem[wp_addr_a];
        wp_rd_b_reg   <= wp_mem[wp_addr_b];
        pp_a_zero_reg <= (pp_addr_a == '0);
        pp_b_zero_reg <= (pp_addr_b == '0);
        wp_a_zero_reg <= (wp_addr_a == '0);
        wp_b_zero_reg <= (wp_addr_b == '0);
    end

    assign done      = done_reg;
    assign answer    = answer_reg;
    assign bad_query = bad_reg;

endmodule

// ----- design/k_nearest_window_distance_sum_unit.sv -----
// Load beat: busy stays low, no result.
// Query beat: done pulses after the window search (s1 = ceil(log2(n-k+1)) read/compare steps),
// the split search (s2 = split-search steps), the prefix fetches pf1-pf3 and the steps ar1-ar3.
// Rejected query: done pulses in the cycle after accept. One query in flight at a time;
// the controller takes start only in its idle state.
// rst_n (async, low) empties the table and idles the controller; no clearing pass.
`include "k_nearest_window_distance_sum_unit_defines.svh"

module k_nearest_window_distance_sum_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                operation,
    input  logic [knwds_pkg::POS_W-1:0]         position_value,
    input  logic signed [knwds_pkg::WGT_W-1:0]  weight_value,
    input  logic [knwds_pkg::POS_W-1:0]         query_point,
    input  logic [knwds_pkg::K_W-1:0]           window_count,
    output logic                                done,
    output logic signed [knwds_pkg::ANS_W-1:0]  answer,
    output logic                                bad_query
);

    knwds_pkg::cmd_t    cmd;
    knwds_pkg::status_t status;
    logic               query_reject;

    knwds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    knwds_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .position_value (position_value),
        .weight_value   (weight_value),
        .query_point    (query_point),
        .window_count   (window_count),
        .done           (done),
        .answer         (answer),
        .bad_query      (bad_query)
    );

    assign query_reject = start && !busy && (operation == knwds_pkg::OP_QUERY) && status.bad;

    `KNWDS_ASSERT_NOW(a_done_idle, done, !busy, "result beat while busy")
    `KNWDS_ASSERT_NEXT(a_bad_beat, query_reject, done && bad_query, "missing error beat")
    `KNWDS_ASSERT_NEXT(a_good_beat, cmd.ar3, done && !bad_query, "missing result beat")
    `KNWDS_ASSERT_NOW(a_busy_cause, $rose(busy), $past(start), "busy rose with no start")

endmodule

// ----- verif/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import knwds_pkg::*;

    localparam logic [POS_W-1:0] PMAX = '1;
    localparam logic [WGT_W-1:0] WMIN = 32'h8000_0000;
    localparam logic [WGT_W-1:0] WMAX = 32'h7FFF_FFFF;
    localparam int RANDOM_BEATS = 1050;
    localparam int FULL_QUERIES = 50;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic              op;
        logic [POS_W-1:0]  pos;
        logic [WGT_W-1:0]  wgt;
        logic [POS_W-1:0]  pt;
        logic [K_W-1:0]    k;
        logic              typed;
        logic [ANS_W-1:0]  ans;
        logic              bad;
    } stim_t;

    typedef struct packed {
        logic signed [ANS_W-1:0] answer;
        logic                    bad;
    } outcome_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     operation;
    logic [POS_W-1:0]         position_value;
    logic signed [WGT_W-1:0]  weight_value;
    logic [POS_W-1:0]         query_point;
    logic [K_W-1:0]           window_count;
    logic                     done;
    logic signed [ANS_W-1:0]  answer;
    logic                     bad_query;

    k_nearest_window_distance_sum_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .position_value (position_value),
        .weight_value   (weight_value),
        .query_point    (query_point),
        .window_count   (window_count),
        .done           (done),
        .answer         (answer),
        .bad_query      (bad_query)
    );

    logic [POS_W-1:0]  entry_pos   [0:MAX_ENTRIES];
    logic [PPRE_W-1:0] pos_run_sum [0:MAX_ENTRIES];
    logic [WPRE_W-1:0] wgt_run_sum [0:MAX_ENTRIES];
    int unsigned       entry_total;

    outcome_t pending_outcomes [$];
    int       mismatches;
    int       quiet_cycles;
    int       idle_pct;

    stim_t script [0:23] = '{
        '{OP_QUERY, 30'd0, 32'd0, 30'd0,    11'd0,    1'b1, 44'd0, 1'b1},
        '{OP_QUERY, 30'd0, 32'd0, PMAX,     11'd1,    1'b1, 44'd0, 1'b1},
        '{OP_LOAD,  30'd0, WMIN,  30'd0,    11'd0,    1'b0, 44'd0, 1'b0},
        '{OP_LOAD,  30'd0, WMAX,  30'd0,    11'd0,    1'b0, 44'd0, 1'b0},
        '{OP_QUERY, 30'd0, 32'd0, 30'd0,    11'd1,    1'b1, 44'hFFF_8000_0000, 1'b0},
        '{OP_QUERY, 30'd0, 32'd0, 30'd0,    11'd2,    1'b1, 44'hFFF_FFFF_FFFF, 1'b0},
        '{OP_QUERY, 30'd0, 32'd0, 30'd0,    11'd3,    1'b1, 44'd0, 1'b1},
        '{OP_QUERY, 30'd0, 32'd0, PMAX,     11'd2047, 1'b1, 44'd0, 1'b1},
        '{OP_LOAD,  30'd10, 32'd0, 30'd0,   11'd0,    1'b0, 44'd0, 1'b0},
        '{OP_LOAD,  30'd20, 32'hFFFF_FFFF, 30'd0, 11'd0, 1'b0, 44'd0, 1'b0},
        '{OP_LOAD,  30'd20, 32'd100, 30'd0, 11'd0,    1'b0, 44'd0, 1'b0},
        '{OP_QUERY, 30'd0, 32'd0, 30'd15,   11'd2,    1'b0, 44'd0, 1'b0},
        '{OP_QUERY, 30'd0, 32'd0, 30'd5,    11'd1,    1'b0, 44'd0, 1'b0},
        '{OP_QUERY, 30'd0, 32'd0, 30'd20,   11'd3,    1'b0, 44'd0, 1'b0},
        '{OP_QUERY, 30'd0, 32'd0, PMAX,     11'd5,    1'b0, 44'd0, 1'b0},
        '{OP_QUERY, 30'd0, 32'd0, 30'd0,    11'd5,    1'b0, 44'd0, 1'b0},
        '{OP_LOAD,  30'd1000, 32'd123456, 30'd0, 11'd0, 1'b0, 44'd0, 1'b0},
        '{OP_LOAD,  30'd30, 32'hFFFF_FFFB, 30'd0, 11'd0, 1'b0, 44'd0, 1'b0},
        '{OP_LOAD,  30'd2000, 32'd7, 30'd0, 11'd0,    1'b0, 44'd0, 1'b0},
        '{OP_QUERY, 30'd0, 32'd0, 30'd25,   11'd3,    1'b0, 44'd0, 1'b0},
        '{OP_QUERY, 30'd0, 32'd0, 30'd1500, 11'd4,    1'b0, 44'd0, 1'b0},
        '{OP_QUERY, 30'd0, 32'd0, PMAX,     11'd1,    1'b0, 44'd0, 1'b0},
        '{OP_QUERY, 30'd0, 32'd0, 30'd0,    11'd8,    1'b0, 44'd0, 1'b0},
        '{OP_QUERY, 30'd0, 32'd0, 30'd0,    11'd9,    1'b1, 44'd0, 1'b1}
    };

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit append_entry(logic [POS_W-1:0] p, logic [WGT_W-1:0] w);
        int unsigned i;
        if (entry_total >= MAX_ENTRIES)
            return 1'b0;
        i = entry_total + 1;
        entry_pos[i]   = p;
        pos_run_sum[i] = pos_run_sum[i-1] + {{(PPRE_W-POS_W){1'b0}}, p};
        wgt_run_sum[i] = wgt_run_sum[i-1] + {{(WPRE_W-WGT_W){w[WGT_W-1]}}, w};
        entry_total    = i;
        return 1'b1;
    endfunction

    function automatic outcome_t window_answer(logic [POS_W-1:0] pt, logic [K_W-1:0] k);
        outcome_t          r;
        int unsigned       n, lo, hi, mid, lft, rgt, first, cnt, stp, probe, t;
        logic [POS_W-1:0]  dl, dr;
        logic [PPRE_W-1:0] lsum, rsum;
        logic [WPRE_W-1:0] wdiff;
        logic [63:0]       dsum, wsum;
        n = entry_total;
        if (k == 0 || k > n)
        begin
            r.answer = '0;
            r.bad    = 1'b1;
            return r;
        end
        lo = 0;
        hi = n - k + 1;
        while (lo + 1 != hi)
        begin
            mid = (lo + hi) >> 1;
            dl = (entry_pos[mid] > pt) ? entry_pos[mid] - pt : pt - entry_pos[mid];
            dr = (entry_pos[mid+k] > pt) ? entry_pos[mid+k] - pt : pt - entry_pos[mid+k];
            if (dl > dr)
                lo = mid;
            else
                hi = mid;
        end
        lft = hi;
        rgt = lft + k - 1;
        first = lft;
        cnt = k;
        while (cnt > 0)
        begin
            stp = cnt >> 1;
            probe = first + stp;
            if (!(pt < entry_pos[probe]))
            begin
                first = probe + 1;
                cnt = cnt - (stp + 1);
            end
            else
                cnt = stp;
        end
        t = first - 1;
        lsum  = pos_run_sum[t] - pos_run_sum[lft-1];
        rsum  = pos_run_sum[rgt] - pos_run_sum[t];
        dsum  = 64'(pt) * 64'(t - lft + 1) - 64'(lsum) + 64'(rsum) - 64'(pt) * 64'(rgt - t);
        wdiff = wgt_run_sum[rgt] - wgt_run_sum[lft-1];
        wsum  = {{(64-WPRE_W){wdiff[WPRE_W-1]}}, wdiff};
        r.answer = ANS_W'(wsum - dsum);
        r.bad    = 1'b0;
        return r;
    endfunction

    task automatic issue(input stim_t s, output bit taken);
        outcome_t o;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start          <= 1'b1;
        operation      <= s.op;
        position_value <= s.pos;
        weight_value   <= s.wgt;
        query_point    <= s.pt;
        window_count   <= s.k;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (s.op == OP_LOAD)
            taken = append_entry(s.pos, s.wgt);
        else
        begin
            taken = 1'b1;
            if (s.typed)
            begin
                o.answer = s.ans;
                o.bad    = s.bad;
            end
            else
                o = window_answer(s.pt, s.k);
            pending_outcomes.push_back(o);
        end
    endtask

    always @(posedge clk)
    begin
        outcome_t exp_o;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (done)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $display("%0t: unexpected result: answer %0d bad_query %0b",
                             $time, answer, bad_query);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    exp_o = pending_outcomes.pop_front();
                    if (answer !== exp_o.answer)
                    begin
                        $display("%0t: answer mismatch: expected %0d, actual %0d",
                                 $time, exp_o.answer, answer);
                        mismatches = mismatches + 1;
                    end
                    if (bad_query !== exp_o.bad)
                    begin
                        $display("%0t: bad_query mismatch: expected %0b, actual %0b",
                                 $time, exp_o.bad, bad_query);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        stim_t           s;
        bit              taken;
        int              rand_beats;
        int              full_queries;
        int unsigned     n;
        int unsigned     sel;
        int unsigned     i;
        longint unsigned sorted_tip;
        longint unsigned stp;
        longint          v;

        rst_n          = 1'b0;
        start          = 1'b0;
        operation      = OP_LOAD;
        position_value = '0;
        weight_value   = '0;
        query_point    = '0;
        window_count   = '0;
        entry_total    = 0;
        pos_run_sum[0] = '0;
        wgt_run_sum[0] = '0;
        mismatches     = 0;
        quiet_cycles   = 0;
        idle_pct       = 33;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[j])
            issue(script[j], taken);

        sorted_tip   = 2000;
        rand_beats   = 0;
        full_queries = 0;
        while (rand_beats < RANDOM_BEATS || entry_total < MAX_ENTRIES
               || full_queries < FULL_QUERIES)
        begin
            idle_pct = (rand_beats < RANDOM_BEATS / 3) ? 33 :
                       (rand_beats < 2 * RANDOM_BEATS / 3) ? 67 : 0;
            n = entry_total;
            s = '0;
            if ($urandom_range(0, 99) < ((n < MAX_ENTRIES) ? 92 : 8))
            begin
                s.op = OP_LOAD;
                if ($urandom_range(0, 19) == 0)
                    s.pos = POS_W'($urandom);
                else
                begin
                    stp = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 1 << 21);
                    sorted_tip = (longint'(PMAX) - sorted_tip < stp) ? PMAX : sorted_tip + stp;
                    s.pos = POS_W'(sorted_tip);
                end
                if ($urandom_range(0, 9) == 0)
                    s.wgt = $urandom_range(0, 1) ? WMAX : WMIN;
                else
                    s.wgt = $urandom;
                s.pt = POS_W'($urandom);
                s.k  = K_W'($urandom);
            end
            else
            begin
                s.op  = OP_QUERY;
                s.pos = POS_W'($urandom);
                s.wgt = $urandom;
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    s.pt = '0;
                else if (sel == 1)
                    s.pt = PMAX;
                else if (sel < 4 || n == 0)
                    s.pt = POS_W'($urandom);
                else if (sel == 4 && n > 1)
                begin
                    i = $urandom_range(1, n - 1);
                    s.pt = POS_W'((longint'(entry_pos[i]) + longint'(entry_pos[i+1])) / 2);
                end
                else
                begin
                    v = longint'(entry_pos[$urandom_range(1, n)]) + $urandom_range(0, 64) - 32;
                    s.pt = (v < 0) ? '0 : (v > longint'(PMAX)) ? PMAX : POS_W'(v);
                end
                sel = $urandom_range(0, 19);
                if (n == 0)
                    s.k = K_W'($urandom_range(0, 2047));
                else if (sel < 2)
                    s.k = $urandom_range(0, 1) ? '0 : K_W'($urandom_range(n + 1, 2047));
                else if (sel == 2)
                    s.k = K_W'(n);
                else if (sel < 11)
                    s.k = K_W'($urandom_range(1, (n < 8) ? n : 8));
                else
                    s.k = K_W'($urandom_range(1, n));
            end
            issue(s, taken);
            if (taken)
                rand_beats = rand_beats + 1;
            if (s.op == OP_QUERY && entry_total == MAX_ENTRIES)
                full_queries = full_queries + 1;
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
